### rtl/dwsg_pkg.sv
`default_nettype none
// ============================================================================
// dwsg_pkg: shared constants, tables and types for the DAC waveform generator
// Holds the period and DAC scaling constants, the amplitude scaling reciprocal,
// the quarter-wave sine table and the configuration bundle type.
// ============================================================================
package dwsg_pkg;

    // Core constants. The period must be a power of two of at least four.
    localparam int SAMPLES_PER_PERIOD = 256;
    localparam int DAC_FULL_SCALE     = 4095;
    localparam int VREF_MILLIVOLTS    = 3300;

    localparam int PHASE_W     = $clog2(SAMPLES_PER_PERIOD);
    localparam int HALF_SHIFT  = PHASE_W - 1;
    localparam int CODE_W      = $clog2(DAC_FULL_SCALE + 1);
    localparam int CENTER      = DAC_FULL_SCALE / 2;
    localparam int AMP_W       = $clog2(CENTER + 1);

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLES_PER_PERIOD - 1);

    // Port widths fixed by the interface.
    localparam int SAMPLE_W      = 12;
    localparam int PHASE_INDEX_W = 8;
    localparam int WAVE_SEL_W    = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE_MV    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BASED      = 2'd2;

    // Waveform codes. The unused code falls back to sine.
    localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 2'd2;

    // Amplitude scaling: amp = floor(mv * FS / (2 * MAX_MV)) computed as a
    // multiply by a rounded-up reciprocal. The shift is large enough that the
    // rounding error never crosses an integer for any legal millivolt value.
    localparam int     MAX_MV     = VREF_MILLIVOLTS / 2;
    localparam int     MV_W       = $clog2(MAX_MV + 1);
    localparam int     AMP_SHIFT  = 24;
    localparam longint AMP_MULT   =
        ((longint'(DAC_FULL_SCALE) << AMP_SHIFT) + longint'(2 * MAX_MV) - 1)
        / longint'(2 * MAX_MV);
    localparam int     MULT_W     = $clog2(AMP_MULT + 1);
    localparam int     PROD_W     = MV_W + MULT_W;

    // Reset value of the scaled amplitude, from 1650 mV.
    localparam int     AMP_MV_RESET  = 1650;
    localparam longint AMP_RESET_MV  =
        (AMP_MV_RESET > MAX_MV) ? longint'(MAX_MV) : longint'(AMP_MV_RESET);
    localparam longint AMP_RESET_RAW = (AMP_RESET_MV * AMP_MULT) >> AMP_SHIFT;
    localparam logic [AMP_W-1:0] AMP_RESET =
        AMP_W'((AMP_RESET_RAW > longint'(CENTER)) ? longint'(CENTER) : AMP_RESET_RAW);

    // Sine in Q1.15, scaled by 32767.
    localparam int SINE_W = 16;
    localparam logic [SINE_W-1:0] SINE_ONE = 16'd32767;

    localparam logic [14:0] QUARTER_SINE [65] = '{
        15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,
        15'd4808,  15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,
        15'd9512,  15'd10278, 15'd11039, 15'd11793, 15'd12539, 15'd13279,
        15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403,
        15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279, 15'd24811,
        15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
        15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580,
        15'd31785, 15'd31971, 15'd32137, 15'd32285, 15'd32412, 15'd32521,
        15'd32609, 15'd32678, 15'd32728, 15'd32757, 15'd32767
    };

    // Configuration as seen by the waveform datapath.
    typedef struct packed {
        logic [WAVE_SEL_W-1:0] wave_sel;
        logic                  zero_based;
        logic [AMP_W-1:0]      amp;
    } t_cfg;

endpackage
`default_nettype wire

### rtl/dwsg_cfg.sv
`default_nettype none
// ============================================================================
// dwsg_cfg: configuration registers
// Holds the waveform select and offset mode, and scales the millivolt
// amplitude into a raw DAC half-span when it is written.
// ============================================================================
module dwsg_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dwsg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [dwsg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output dwsg_pkg::t_cfg                          o_cfg
);

    localparam int RAW_W = dwsg_pkg::PROD_W - dwsg_pkg::AMP_SHIFT;

    logic [dwsg_pkg::WAVE_SEL_W-1:0] r_wave_sel;
    logic                            r_zero_based;
    logic [dwsg_pkg::AMP_W-1:0]      r_amp;
    logic [dwsg_pkg::AMP_W-1:0]      n_amp;

    logic [dwsg_pkg::MV_W-1:0]       mv_clamped;
    logic [dwsg_pkg::PROD_W-1:0]     amp_prod;
    logic [RAW_W-1:0]                amp_raw;

    // Clamp to half the reference, then multiply by the reciprocal.
    always_comb begin
        if (i_cfg_data > dwsg_pkg::CFG_DATA_W'(dwsg_pkg::MAX_MV)) begin
            mv_clamped = dwsg_pkg::MV_W'(dwsg_pkg::MAX_MV);
        end else begin
            mv_clamped = dwsg_pkg::MV_W'(i_cfg_data);
        end
        amp_prod = dwsg_pkg::PROD_W'(mv_clamped) * dwsg_pkg::PROD_W'(dwsg_pkg::AMP_MULT);
        amp_raw  = amp_prod[dwsg_pkg::PROD_W-1:dwsg_pkg::AMP_SHIFT];
        if (amp_raw > RAW_W'(dwsg_pkg::CENTER)) begin
            n_amp = dwsg_pkg::AMP_W'(dwsg_pkg::CENTER);
        end else begin
            n_amp = dwsg_pkg::AMP_W'(amp_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel   <= dwsg_pkg::WAVE_SINE;
            r_zero_based <= 1'b1;
            r_amp        <= dwsg_pkg::AMP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dwsg_pkg::REG_WAVEFORM_SELECT: begin
                    r_wave_sel <= i_cfg_data[dwsg_pkg::WAVE_SEL_W-1:0];
                end
                dwsg_pkg::REG_AMPLITUDE_MV: begin
                    r_amp <= n_amp;
                end
                dwsg_pkg::REG_ZERO_BASED: begin
                    r_zero_based <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.wave_sel   = r_wave_sel;
    assign o_cfg.zero_based = r_zero_based;
    assign o_cfg.amp        = r_amp;

endmodule
`default_nettype wire

### rtl/dwsg_wave.sv
`default_nettype none
// ============================================================================
// dwsg_wave: waveform code datapath
// Turns one phase position and the current configuration into a DAC code for
// the sine, square or triangle wave.
// ============================================================================
module dwsg_wave (
    input  wire dwsg_pkg::t_cfg                     i_cfg,
    input  wire logic [dwsg_pkg::PHASE_W-1:0]       i_phase,
    output logic      [dwsg_pkg::SAMPLE_W-1:0]      o_code
);

    localparam int CODE_W = dwsg_pkg::CODE_W;
    localparam int AMP_W  = dwsg_pkg::AMP_W;
    localparam int X_W    = dwsg_pkg::SINE_W + AMP_W;
    localparam int Q_W    = X_W - 15;
    localparam int STEP_W = CODE_W + dwsg_pkg::HALF_SHIFT;

    logic [dwsg_pkg::PHASE_W+7:0] k_wide;
    logic [7:0]                   k;
    logic [6:0]                   tab_idx;
    logic [14:0]                  mag;
    logic [dwsg_pkg::SINE_W-1:0]  sine_ofs;
    logic [X_W-1:0]               sine_prod;
    logic [Q_W-1:0]               q0;
    logic [15:0]                  rem0;
    logic [CODE_W:0]              sine_z;
    logic [CODE_W+1:0]            sine_sum;
    logic [CODE_W-1:0]            sine_code;

    logic [CODE_W:0]              hi_raw;
    logic [CODE_W-1:0]            hi;
    logic [CODE_W-1:0]            lo_raw;
    logic [CODE_W-1:0]            lo;
    logic [CODE_W-1:0]            span;
    logic                         first_half;
    logic [STEP_W-1:0]            step_prod;
    logic [CODE_W-1:0]            step;
    logic [CODE_W-1:0]            tri_code;
    logic [CODE_W-1:0]            code;

    // Sine: the offset value s + 32767 times amp, divided by 2^15 - 1.
    // Writing x = q0 * 2^15 + lo gives x = q0 * (2^15 - 1) + (lo + q0), and
    // that remainder stays below twice the divisor, so one correction does.
    // The centered form follows from the same quotient minus amp.
    always_comb begin
        k_wide   = {i_phase, 8'd0} >> dwsg_pkg::PHASE_W;
        k        = k_wide[7:0];
        tab_idx  = k[6] ? (7'd64 - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
        mag      = dwsg_pkg::QUARTER_SINE[tab_idx];
        sine_ofs = k[7] ? (dwsg_pkg::SINE_ONE - dwsg_pkg::SINE_W'(mag))
                        : (dwsg_pkg::SINE_ONE + dwsg_pkg::SINE_W'(mag));
        sine_prod = X_W'(sine_ofs) * X_W'(i_cfg.amp);
        q0        = sine_prod[X_W-1:15];
        rem0      = 16'(sine_prod[14:0]) + 16'(q0);
        if (rem0 >= dwsg_pkg::SINE_ONE) begin
            sine_z = (CODE_W+1)'(q0) + 1'b1;
        end else begin
            sine_z = (CODE_W+1)'(q0);
        end
        if (i_cfg.zero_based) begin
            sine_sum = (CODE_W+2)'(sine_z);
        end else begin
            sine_sum = (CODE_W+2)'(dwsg_pkg::CENTER) - (CODE_W+2)'(i_cfg.amp)
                     + (CODE_W+2)'(sine_z);
        end
        if (sine_sum > (CODE_W+2)'(dwsg_pkg::DAC_FULL_SCALE)) begin
            sine_code = CODE_W'(dwsg_pkg::DAC_FULL_SCALE);
        end else begin
            sine_code = CODE_W'(sine_sum);
        end
    end

    // High and low levels shared by the square and triangle.
    always_comb begin
        if (i_cfg.zero_based) begin
            hi_raw = (CODE_W+1)'(i_cfg.amp) << 1;
            lo_raw = '0;
        end else begin
            hi_raw = (CODE_W+1)'(dwsg_pkg::CENTER) + (CODE_W+1)'(i_cfg.amp);
            if (CODE_W'(dwsg_pkg::CENTER) >= CODE_W'(i_cfg.amp)) begin
                lo_raw = CODE_W'(dwsg_pkg::CENTER) - CODE_W'(i_cfg.amp);
            end else begin
                lo_raw = '0;
            end
        end
        if (hi_raw > (CODE_W+1)'(dwsg_pkg::DAC_FULL_SCALE)) begin
            hi = CODE_W'(dwsg_pkg::DAC_FULL_SCALE);
        end else begin
            hi = CODE_W'(hi_raw);
        end
        lo = (lo_raw > hi) ? hi : lo_raw;
    end

    // Triangle: the position within the current half period scales the span.
    always_comb begin
        first_half = !i_phase[dwsg_pkg::PHASE_W-1];
        span       = hi - lo;
        step_prod  = STEP_W'(span) * STEP_W'(i_phase[dwsg_pkg::PHASE_W-2:0]);
        step       = CODE_W'(step_prod >> dwsg_pkg::HALF_SHIFT);
        if (i_phase == '0 || i_phase == dwsg_pkg::PHASE_LAST) begin
            tri_code = lo;
        end else if (first_half) begin
            tri_code = lo + step;
        end else begin
            tri_code = hi - step;
        end
    end

    always_comb begin
        unique case (i_cfg.wave_sel)
            dwsg_pkg::WAVE_SQUARE:   code = first_half ? hi : lo;
            dwsg_pkg::WAVE_TRIANGLE: code = tri_code;
            default:                 code = sine_code;
        endcase
        o_code = dwsg_pkg::SAMPLE_W'(code);
    end

endmodule
`default_nettype wire

### rtl/dac_waveform_sample_generator.sv
`default_nettype none
// ============================================================================
// dac_waveform_sample_generator: sine, square and triangle DAC sample source
// Produces one DAC code per update beat from a phase counter that walks
// through one period, with configurable shape, amplitude and offset mode.
// ============================================================================
// The block takes one update beat per clock cycle and returns its result beat
// the next cycle from an output register; a new beat is accepted whenever the
// output register is empty or its contents are being taken in the same cycle,
// so a steady stream runs at one sample per cycle and a stalled output holds
// at most one sample. Each input beat is a tick that may restart the phase at
// zero; otherwise the phase advances by one and wraps after the last sample
// of the period, which is flagged with period_end. The sample is a DAC code
// clamped to full scale. Waveform select 0 or 3 gives a sine from a Q1.15
// quarter-wave table, 1 a square that is high for the first half period, and
// 2 a triangle that rises over the first half and falls over the second, with
// its first and last samples forced to the low level. The amplitude register
// takes millivolts, is clamped to half the reference voltage and is scaled to
// a raw half-span by a multiplier at write time, so the new value is in
// effect from the next cycle on. With zero_based set the wave spans zero to
// twice that half-span; otherwise it swings around mid-scale. Configuration
// writes are intended for idle periods; they take effect at once.
// ============================================================================
module dac_waveform_sample_generator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    // Update tick channel.
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_restart,

    // Sample channel.
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic      [dwsg_pkg::SAMPLE_W-1:0]         o_sample,
    output logic      [dwsg_pkg::PHASE_INDEX_W-1:0]    o_phase_index,
    output logic                                       o_period_end,

    // Configuration write port.
    input  wire logic                                  i_cfg_we,
    input  wire logic [dwsg_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [dwsg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    dwsg_pkg::t_cfg                      cfg;

    logic [dwsg_pkg::PHASE_W-1:0]        r_phase;
    logic [dwsg_pkg::PHASE_W-1:0]        n_phase;
    logic [dwsg_pkg::PHASE_W-1:0]        cur_phase;
    logic [dwsg_pkg::SAMPLE_W-1:0]       wave_code;
    logic                                in_fire;
    logic                                is_last;

    logic                                r_out_valid;
    logic [dwsg_pkg::SAMPLE_W-1:0]       r_sample;
    logic [dwsg_pkg::PHASE_INDEX_W-1:0]  r_phase_index;
    logic                                r_period_end;

    dwsg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The output register is the only buffer: accept when it is free or
    // being drained in this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // A restart beat uses phase zero for its own sample.
    always_comb begin
        cur_phase = i_restart ? '0 : r_phase;
        is_last   = (cur_phase == dwsg_pkg::PHASE_LAST);
        n_phase   = is_last ? '0 : cur_phase + 1'b1;
    end

    dwsg_wave u_wave (
        .i_cfg   (cfg),
        .i_phase (cur_phase),
        .o_code  (wave_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample      <= wave_code;
            r_phase_index <= dwsg_pkg::PHASE_INDEX_W'(cur_phase);
            r_period_end  <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_sample;
    assign o_phase_index = r_phase_index;
    assign o_period_end  = r_period_end;

`ifndef SYNTHESIS
    // A restart beat must come out as the first sample of a period.
    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_restart |=> o_out_valid && r_phase_index == '0)
        else $error("restart beat did not produce phase zero");

    // The period end flag and the phase wrap must agree.
    a_period_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_period_end == (r_phase == '0))
        else $error("period_end does not match the phase wrap");

    // Without restart or wrap, the phase advances by exactly one.
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_restart && r_phase != dwsg_pkg::PHASE_LAST
        |=> r_phase == dwsg_pkg::PHASE_W'($past(r_phase) + 1'b1))
        else $error("phase did not advance by one");
`endif

endmodule
`default_nettype wire

### sim/dwsg_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// dwsg_checker: sample predictor and scoreboard for the DAC waveform generator
// Watches the tick, sample and register-write ports, predicts each DAC sample
// from its own phase counter and register copy, and compares every field.
// ============================================================================
module dwsg_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_restart,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [dwsg_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic [dwsg_pkg::PHASE_INDEX_W-1:0]  i_phase_index,
    input  logic                                i_period_end,
    input  logic                                i_cfg_we,
    input  logic [dwsg_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [dwsg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import dwsg_pkg::*;

    localparam longint Q15_UNITY  = 32767;
    localparam int     PRINT_CAP  = 40;

    // Quarter sine wave, 65 points, scaled by 32767 and rounded.
    localparam int SINE_QUADRANT [65] = '{
        0, 804, 1608, 2410, 3212, 4011, 4808, 5602, 6393, 7179,
        7962, 8739, 9512, 10278, 11039, 11793, 12539, 13279, 14010, 14732,
        15446, 16151, 16846, 17530, 18204, 18868, 19519, 20159, 20787, 21403,
        22005, 22594, 23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956, 30273, 30571,
        30852, 31113, 31356, 31580, 31785, 31971, 32137, 32285, 32412, 32521,
        32609, 32678, 32728, 32757, 32767
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0]      sample;
        logic [PHASE_INDEX_W-1:0] phase_index;
        logic                     period_end;
    } dac_word_t;

    // Register and phase copies.
    logic [WAVE_SEL_W-1:0] shape;
    logic [CFG_DATA_W-1:0] amp_mv;
    logic                  zero_based;
    int unsigned           phase_ctr;

    dac_word_t expected_words[$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string detail);
        if (o_mismatches < PRINT_CAP) begin
            $display("[%0t] sample check: %s", $time, detail);
        end
        o_mismatches++;
    endtask

    function automatic longint half_span_code();
        longint maxmv;
        longint mv;
        longint raw;
        maxmv = VREF_MILLIVOLTS / 2;
        mv    = longint'(amp_mv);
        if (mv > maxmv) begin
            mv = maxmv;
        end
        raw = (mv * DAC_FULL_SCALE) / (2 * maxmv);
        if (raw > DAC_FULL_SCALE / 2) begin
            raw = DAC_FULL_SCALE / 2;
        end
        return raw;
    endfunction

    // Works out the DAC word for one tick and advances the phase copy.
    function automatic dac_word_t next_dac_sample(input logic restart);
        dac_word_t   w;
        int unsigned ph;
        int unsigned k;
        int unsigned r;
        longint      amp;
        longint      mid;
        longint      hi;
        longint      lo;
        longint      d;
        longint      s;
        longint      p;
        longint      q;
        longint      v;
        longint      step;
        if (restart || phase_ctr >= SAMPLES_PER_PERIOD) begin
            phase_ctr = 0;
        end
        ph  = phase_ctr;
        amp = half_span_code();
        mid = DAC_FULL_SCALE / 2;
        if (zero_based) begin
            hi = 2 * amp;
            lo = 0;
        end else begin
            hi = mid + amp;
            lo = (mid >= amp) ? mid - amp : 0;
        end
        if (hi > DAC_FULL_SCALE) begin
            hi = DAC_FULL_SCALE;
        end
        if (lo > hi) begin
            lo = hi;
        end
        case (shape)
            WAVE_SQUARE: begin
                v = (ph < SAMPLES_PER_PERIOD / 2) ? hi : lo;
            end
            WAVE_TRIANGLE: begin
                d = hi - lo;
                if (ph == 0 || ph == SAMPLES_PER_PERIOD - 1) begin
                    v = lo;
                end else if (ph < SAMPLES_PER_PERIOD / 2) begin
                    v = lo + (d * ph) / (SAMPLES_PER_PERIOD / 2);
                end else begin
                    step = (d * (ph - SAMPLES_PER_PERIOD / 2)) / (SAMPLES_PER_PERIOD / 2);
                    if (step > d) begin
                        step = d;
                    end
                    v = hi - step;
                end
            end
            default: begin
                k = ((ph * 256) / SAMPLES_PER_PERIOD) & 255;
                r = k & 63;
                case (k >> 6)
                    0:       s = SINE_QUADRANT[r];
                    1:       s = SINE_QUADRANT[64 - r];
                    2:       s = -SINE_QUADRANT[r];
                    default: s = -SINE_QUADRANT[64 - r];
                endcase
                if (zero_based) begin
                    v = ((s + Q15_UNITY) * amp) / Q15_UNITY;
                end else begin
                    // Mid-scale mode floors toward minus infinity.
                    p = s * amp;
                    if (p >= 0) begin
                        q = p / Q15_UNITY;
                    end else begin
                        q = -((-p + Q15_UNITY - 1) / Q15_UNITY);
                    end
                    v = mid + q;
                end
                if (v < 0) begin
                    v = 0;
                end
                if (v > DAC_FULL_SCALE) begin
                    v = DAC_FULL_SCALE;
                end
            end
        endcase
        w.sample      = SAMPLE_W'(v);
        w.phase_index = PHASE_INDEX_W'(ph);
        w.period_end  = (ph == SAMPLES_PER_PERIOD - 1);
        phase_ctr     = (ph + 1 >= SAMPLES_PER_PERIOD) ? 0 : ph + 1;
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        dac_word_t want;
        if (!i_rst_n) begin
            shape      = WAVE_SINE;
            amp_mv     = CFG_DATA_W'(1650);
            zero_based = 1'b1;
            phase_ctr  = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WAVEFORM_SELECT: shape      = i_cfg_data[WAVE_SEL_W-1:0];
                    REG_AMPLITUDE_MV:    amp_mv     = i_cfg_data;
                    REG_ZERO_BASED:      zero_based = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("sample beat %0d with nothing expected",
                                              i_sample));
                end else begin
                    want = expected_words.pop_front();
                    if (i_sample !== want.sample) begin
                        report_mismatch($sformatf("sample %0d, expected %0d (phase %0d)",
                                                  i_sample, want.sample, want.phase_index));
                    end
                    if (i_phase_index !== want.phase_index) begin
                        report_mismatch($sformatf("phase_index %0d, expected %0d",
                                                  i_phase_index, want.phase_index));
                    end
                    if (i_period_end !== want.period_end) begin
                        report_mismatch($sformatf("period_end %0b, expected %0b at phase %0d",
                                                  i_period_end, want.period_end,
                                                  want.phase_index));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(next_dac_sample(i_restart));
            end
        end
        o_outstanding = expected_words.size();
    end

endmodule

### sim/tb_dac_waveform_sample_generator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_dac_waveform_sample_generator: stimulus and verdict for the DAC generator
// Drives update ticks and register settings through directed and random
// phases with varied back-pressure; a separate checker predicts every sample.
// ============================================================================
module tb_dac_waveform_sample_generator;
    import dwsg_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    // The limit lies far above the length of any legal run, so only a hung
    // handshake can reach it.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 16;
    localparam int BEATS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES   = 4;

    // The index past the last register; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // Idle patterns, cycled through the random phases.
    localparam int MODE_STEADY     = 0;
    localparam int MODE_SENDER_GAP = 1;
    localparam int MODE_RECV_STALL = 2;
    localparam int MODE_BOTH       = 3;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_restart;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [SAMPLE_W-1:0]       o_sample;
    logic [PHASE_INDEX_W-1:0]  o_phase_index;
    logic                      o_period_end;
    logic                      i_cfg_we;
    logic [CFG_INDEX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int mismatches;
    int outstanding;
    int cycle_count;
    int beats_sent;
    int settings_used;
    int sender_gap_pct;
    int receiver_stall_pct;
    bit hold_request;

    dac_waveform_sample_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample),
        .o_phase_index (o_phase_index),
        .o_period_end  (o_period_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // The checker sits beside the block and sees exactly what crosses its
    // ports; it owns the prediction and the comparison.
    dwsg_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_restart     (i_restart),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_sample      (o_sample),
        .i_phase_index (o_phase_index),
        .i_period_end  (o_period_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog: a stuck handshake ends the run here rather than hanging.
    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sample receiver. Outside a hold it stalls at the current phase's rate.
    // A hold request makes it refuse samples for a long stretch so that the
    // block's output register fills and it has to push back on the ticks.
    initial begin
        i_out_ready  = 1'b0;
        hold_request = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_out_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offers one tick. Random gaps come first; once valid is raised it stays
    // up with the same restart bit until the block takes the beat. The task
    // returns on the falling edge after acceptance, so the next call can
    // either keep valid high or drop it without touching it twice.
    task automatic send_beat(input logic restart_bit);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart_bit;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Stops offering ticks and waits until every predicted sample came out.
    // After that the block is idle and registers may be written.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Writes all three registers on consecutive cycles, then pokes the
    // unused index with random data, which the block must ignore.
    task automatic program_setting(input logic [CFG_DATA_W-1:0] wave_raw,
                                   input logic [CFG_DATA_W-1:0] mv,
                                   input logic [CFG_DATA_W-1:0] zb_raw);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WAVEFORM_SELECT;
        i_cfg_data  <= wave_raw;
        @(negedge i_clk);
        i_cfg_index <= REG_AMPLITUDE_MV;
        i_cfg_data  <= mv;
        @(negedge i_clk);
        i_cfg_index <= REG_ZERO_BASED;
        i_cfg_data  <= zb_raw;
        @(negedge i_clk);
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            MODE_SENDER_GAP: begin
                sender_gap_pct     = 45;
                receiver_stall_pct = 0;
            end
            MODE_RECV_STALL: begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 45;
            end
            MODE_BOTH: begin
                sender_gap_pct     = 9;
                receiver_stall_pct = 9;
            end
            default: begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // Amplitude corner values: zero, the smallest step, both sides of the
    // clamp at half the reference, and the register maximum.
    function automatic logic [CFG_DATA_W-1:0] amplitude_corner(input int sel);
        case (sel % 6)
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(1649);
            3:       return CFG_DATA_W'(1650);
            4:       return CFG_DATA_W'(1651);
            default: return CFG_DATA_W'(65535);
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] wave_raw;
        logic [CFG_DATA_W-1:0] mv;
        logic [CFG_DATA_W-1:0] zb_raw;
        int                    restart_pct;

        // Every input starts known; reset is held for a fixed number of
        // cycles and then released once for the rest of the run.
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_restart     = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_WAVEFORM_SELECT;
        i_cfg_data    = '0;
        beats_sent    = 0;
        settings_used = 0;
        set_idle_mode(MODE_STEADY);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First the reset settings (sine, 1650 mV, zero-based)
        // with a restart in the middle of a run of ticks.
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);

        // Square at the start of the high half.
        wait_drained();
        program_setting(CFG_DATA_W'(WAVE_SQUARE), CFG_DATA_W'(1650), CFG_DATA_W'(1));
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);

        // Triangle through masked data: upper bits set on the select and
        // offset registers, amplitude far above the clamp, mid-scale mode.
        // The first tick after restart must be forced to the low level.
        wait_drained();
        program_setting(16'hFFFE, 16'hFFFF, 16'h0002);
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);

        // Spare select code falls back to sine; zero amplitude.
        wait_drained();
        program_setting(16'hFFFF, CFG_DATA_W'(0), CFG_DATA_W'(1));
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);

        // Square, mid-scale, full reference requested; the phase carries on.
        wait_drained();
        program_setting(CFG_DATA_W'(WAVE_SQUARE), CFG_DATA_W'(3300), CFG_DATA_W'(0));
        repeat (3) send_beat(1'b0);

        // Random part. The first eight phases sweep every select code with
        // both offset modes and the amplitude corners; the rest pick settings
        // at random. Restarts are rare in most phases so the phase walks whole
        // periods and reaches the last sample and the wrap; every fifth phase
        // restarts often to break periods up.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            if (p < 8) begin
                wave_raw = (CFG_DATA_W'($urandom) & 16'hFFFC) | CFG_DATA_W'(p % 4);
                zb_raw   = (CFG_DATA_W'($urandom) & 16'hFFFE) | CFG_DATA_W'((p / 4) % 2);
                mv       = amplitude_corner(p);
            end else begin
                wave_raw = CFG_DATA_W'($urandom);
                zb_raw   = CFG_DATA_W'($urandom);
                case ($urandom_range(2))
                    0:       mv = amplitude_corner($urandom_range(5));
                    1:       mv = CFG_DATA_W'($urandom_range(1700));
                    default: mv = CFG_DATA_W'($urandom);
                endcase
            end
            program_setting(wave_raw, mv, zb_raw);
            set_idle_mode(p % 4);
            restart_pct = (p % 5 == 4) ? 25 : 2;

            // One steady phase gets the long receiver hold: ticks keep coming
            // while samples are refused, so the block must stall its input.
            if (p == 4) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                send_beat($urandom_range(99) < restart_pct);
            end
        end

        // Let everything drain, then give the block a few more cycles to
        // show any sample that should not be there.
        wait_drained();
        set_idle_mode(MODE_STEADY);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Covered %0d update beats under %0d register settings in %0d cycles.",
                 beats_sent, settings_used, cycle_count);
        $display("Shapes sine, square, triangle and the spare code; both offset modes; %s",
                 "amplitudes from 0 mV past the clamp; long output hold included.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
